[design/lsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scan line decoder package
// Character codes, result kinds, the result record and shared helpers.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam logic [7:0]  CHAR_LF   = 8'h0A;
  localparam logic [7:0]  CHAR_G    = 8'h47;
  localparam logic [7:0]  CHAR_D    = 8'h44;
  localparam logic [7:0]  CHAR_ZERO = 8'h30;
  localparam logic [7:0]  CHAR_P    = 8'h50;

  localparam logic [2:0]  LINE_TS_LEN = 3'd5;
  localparam logic [2:0]  LINE_SAT    = 3'd6;

  localparam logic [11:0] FRAME_POINTS_RESET = 12'd1081;
  localparam logic [12:0] COUNT_MAX          = 13'h1FFF;
  localparam int          MAX_POINTS_DEFAULT = 2048;

  typedef enum logic [1:0] {
    KIND_POINT     = 2'd0,
    KIND_FRAME_END = 2'd1,
    KIND_TIMESTAMP = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [10:0]  index;
    logic [17:0]  value;
    logic         ok;
    logic         last;
  } result_t;

  // Results produced by one byte, at most two.
  typedef struct packed {
    logic [1:0]         count;
    result_t [1:0]      res;
  } push_t;

  function automatic logic [5:0] six_bits(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - CHAR_ZERO;
    return diff[5:0];
  endfunction

endpackage
`default_nettype wire

[design/lsd_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scan line decoder core
// Line state, character groups and frame counters, updated once per byte.
// ----------------------------------------------------------------------------
module lsd_decode
  import lsd_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_data_i,
  output push_t            push_o
);

  logic [11:0]     fp_q;
  logic [2:0]      len_q, len_d;
  logic [4:0][7:0] held_q, held_d;
  logic [5:0]      g0_q, g0_d, g1_q, g1_d;
  logic [1:0]      fill_q, fill_d;
  logic [12:0]     cnt_q, cnt_d;
  logic [11:0]     pidx_q, pidx_d;
  logic            seen_q, seen_d;

  logic is_gd, is_00p;

  assign is_gd  = (len_q >= 3'd2) && (held_q[0] == CHAR_G) && (held_q[1] == CHAR_D);
  assign is_00p = (len_q >= 3'd3) && (held_q[0] == CHAR_ZERO) &&
                  (held_q[1] == CHAR_ZERO) && (held_q[2] == CHAR_P);

  always_comb begin : decode
    logic [1:0]      fill;
    logic [5:0]      g0, g1, v;
    logic [12:0]     cnt;
    logic [11:0]     pidx;
    logic [1:0]      n;
    result_t [1:0]   res;
    logic [4:0]      ap_en;
    logic [4:0][7:0] ap_chr;
    logic [13:0]     expect_cnt;

    fill       = fill_q;
    g0         = g0_q;
    g1         = g1_q;
    cnt        = cnt_q;
    pidx       = pidx_q;
    n          = 2'd0;
    res        = '0;
    ap_en      = '0;
    ap_chr     = held_q;
    v          = '0;
    expect_cnt = {1'b0, fp_q, 1'b0} + {2'b00, fp_q};
    len_d      = len_q;
    held_d     = held_q;
    seen_d     = seen_q;

    if (en_i) begin
      if (byte_i == CHAR_LF) begin
        len_d = 3'd0;
        if (len_q != 3'd0) begin
          if (is_gd) begin
            if (seen_q) begin
              res[0].kind = KIND_FRAME_END;
              res[0].ok   = ({1'b0, cnt_q} == expect_cnt);
              n           = 2'd1;
              cnt         = '0;
              fill        = '0;
              g0          = '0;
              g1          = '0;
              pidx        = '0;
              seen_d      = 1'b0;
            end
          end else if (is_00p) begin
            // Status line, dropped.
          end else if (len_q == LINE_TS_LEN) begin
            res[0].kind  = KIND_TIMESTAMP;
            res[0].value = {six_bits(held_q[0]), six_bits(held_q[1]), six_bits(held_q[2])};
            n            = 2'd1;
            seen_d       = 1'b0;
          end else if (len_q >= LINE_SAT) begin
            // The pending character is the checksum.
            seen_d = 1'b1;
          end else begin
            // Short data line: everything but its last character.
            for (int i = 0; i < 4; i++) begin
              ap_en[i] = (3'(i + 1) < len_q);
            end
            seen_d = 1'b1;
          end
        end
      end else if (len_q < LINE_TS_LEN) begin
        held_d[len_q] = byte_i;
        len_d         = len_q + 3'd1;
      end else if (len_q == LINE_TS_LEN) begin
        len_d = LINE_SAT;
        if (!(is_gd || is_00p)) begin
          ap_en     = 5'b11111;
          held_d[4] = byte_i;
        end
      end else if (!(is_gd || is_00p)) begin
        ap_en[0]  = 1'b1;
        ap_chr[0] = held_q[4];
        held_d[4] = byte_i;
      end
    end

    for (int i = 0; i < 5; i++) begin
      if (ap_en[i]) begin
        v = six_bits(ap_chr[i]);
        if (fill != 2'd2) begin
          if (fill == 2'd0) begin
            g0 = v;
          end else begin
            g1 = v;
          end
          fill = fill + 2'd1;
        end else begin
          fill = 2'd0;
          if (cnt < COUNT_MAX) begin
            if ((pidx < fp_q) && (32'(pidx) < MAX_POINTS)) begin
              res[n[0]].kind  = KIND_POINT;
              res[n[0]].index = pidx[10:0];
              res[n[0]].value = {g0, g1, v};
              n               = n + 2'd1;
            end
            pidx = pidx + 12'd1;
          end
        end
        if (cnt < COUNT_MAX) begin
          cnt = cnt + 13'd1;
        end
      end
    end

    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last = 1'b1;
    end

    fill_d       = fill;
    g0_d         = g0;
    g1_d         = g1;
    cnt_d        = cnt;
    pidx_d       = pidx;
    push_o.count = n;
    push_o.res   = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q   <= FRAME_POINTS_RESET;
      len_q  <= '0;
      g0_q   <= '0;
      g1_q   <= '0;
      fill_q <= '0;
      cnt_q  <= '0;
      pidx_q <= '0;
      seen_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fp_q <= cfg_data_i;
      end
      len_q  <= len_d;
      g0_q   <= g0_d;
      g1_q   <= g1_d;
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      pidx_q <= pidx_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("group fill out of range");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LINE_SAT)
    else $error("line length out of range");

  a_idle_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |-> (push_o.count == 2'd0) ##1 $stable(cnt_q))
    else $error("state or results changed without a byte");

endmodule
`default_nettype wire

[design/lsd_result_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scan line decoder result queue
// Four-entry queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module lsd_result_fifo
  import lsd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  input  wire logic  pop_i,
  output result_t    head_o,
  output logic       valid_o,
  output logic       room_o
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  result_t           mem_q [DEPTH];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       count_q;

  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= (AW + 1)'(DEPTH - 2));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + AW'(push_i.count);
      rd_q    <= rd_q + AW'(pop_i);
      count_q <= count_q + (AW + 1)'(push_i.count) - (AW + 1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.res[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + AW'(1)] <= push_i.res[1];
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW + 1)'(DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("results written without room");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && valid_o && push_i.count == 2'd0) |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not drain the queue");

endmodule
`default_nettype wire

[design/lidar_scan_line_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar scan line decoder
// Splits a rangefinder reply stream into lines and decodes distances,
// timestamps and frame ends.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                 Payload
//  in       in   in_valid_i / in_ready_o   data_byte_i
//  out      out  out_valid_o / out_ready_i kind_o, point_index_o, value_o,
//                                          frame_ok_o, last_o
//  cfg      in   cfg_valid_i / cfg_ready_o cfg_data_i (frame_points)
//
// One byte is accepted per cycle while the result queue has room. A byte is
// decoded while it sits in the input register, its results enter the queue
// at the next edge, and its first result is offered once earlier results leave.
// A byte that releases two distances occupies two slots of the four-entry
// result queue, and the queue's output port hands them out one at a time.
// No clearing pass after reset. A stalled output fills the queue, and input
// stalls once fewer than two slots are free.
// ----------------------------------------------------------------------------
module lidar_scan_line_decoder
  import lsd_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [10:0]      point_index_o,
  output logic [17:0]      value_o,
  output logic             frame_ok_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [11:0] cfg_data_i
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       advance, room;
  push_t      push;
  result_t    head;

  assign advance     = vld_q && room;
  assign in_ready_o  = !vld_q || advance;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (advance) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  lsd_decode #(
    .MAX_POINTS(MAX_POINTS)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .byte_i     (byte_q),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push_o     (push)
  );

  lsd_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && out_ready_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .room_o  (room)
  );

  assign kind_o        = head.kind;
  assign point_index_o = head.index;
  assign value_o       = head.value;
  assign frame_ok_o    = head.ok;
  assign last_o        = head.last;

endmodule
`default_nettype wire
